@@ design/fvn_pkg.sv @@
// Shared types and constants for the fractal value-noise block.
`timescale 1ns / 1ps
package fvn_pkg;

  // parameter defaults
  localparam int OCTAVES_DEF  = 2;
  localparam int MAP_SIZE_DEF = 1024;

  // register map
  typedef enum logic [1:0] {
    REG_OFFSET  = 2'd0,
    REG_FREQ    = 2'd1,
    REG_AMP     = 2'd2,
    REG_PERSIST = 2'd3
  } cfg_reg_t;

  // reset values of the registers
  localparam logic [31:0] OFFSET_RST  = 32'd0;
  localparam logic [15:0] FREQ_RST    = 16'd6554;
  localparam logic [23:0] AMP_RST     = 24'd167772;
  localparam logic [15:0] PERSIST_RST = 16'd13107;

  // lattice hash constants
  localparam logic [31:0] HASH_Y_MUL = 32'd57;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_SQ_MUL = 32'd15731;
  localparam logic [31:0] HASH_ADD1  = 32'd789221;
  localparam logic [31:0] HASH_ADD2  = 32'd1376312589;
  localparam logic [31:0] HASH_MASK  = 32'h7fffffff;
  localparam logic [31:0] HASH_ONE   = 32'h40000000;

  localparam int HASH_LAT   = 4;   // stages in the hash unit
  localparam int OCTAVE_LAT = 9;   // stages in one octave lane
  localparam int PIPE_DEPTH = 2 + OCTAVE_LAT + 2;

  typedef logic [32:0]        shifted_t;   // Q.8 shifted coordinate
  typedef logic signed [31:0] hash_t;      // Q2.30 lattice value
  typedef logic signed [35:0] smooth_t;    // Q.34 smoothed value
  typedef logic signed [25:0] contrib_t;   // Q.24 octave contribution

endpackage

@@ design/fractal_value_noise_2d.sv @@
// Top level of the fractal 2D value-noise generator.
// Usage: each transfer on the in_ channel carries one map coordinate pair; one
// result (total_value in signed Q8.24 and a 3-bit level) leaves on the out_
// channel for each one, in order. Registers are written on the cfg_ channel
// (cfg_ready is always high); the user must do so only while no item is in
// flight, which the block itself does not enforce. One item is taken every
// cycle unless out_stall holds the pipeline: every stage is a register and
// each octave has its own lane (16 hash units of four stages each).
// The per-octave amplitudes are a register chain that settles after a write,
// well before an item reaches the weighting stage.
// Reset: the valid bits clear and the registers take their defaults; the
// pipeline is empty afterwards.
// Stall: when out_stall is high with a result waiting, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module fractal_value_noise_2d #(
  parameter int OCTAVES  = fvn_pkg::OCTAVES_DEF,
  parameter int MAP_SIZE = fvn_pkg::MAP_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [9:0]         in_coord_x,
  input  wire logic [9:0]         in_coord_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_total_value,
  output logic [2:0]              out_level,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire fvn_pkg::cfg_reg_t  cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int RECIP = (1 << 20) / MAP_SIZE;
  localparam int DEPTH = fvn_pkg::PIPE_DEPTH;

  logic en;
  logic [DEPTH-1:0] vld_r;
  logic [31:0] offset_r;
  logic [15:0] freq_r, pers_r;
  logic [23:0] amp_cfg_r;
  logic [23:0] amp_r [OCTAVES];
  logic [9:0] cx_r, cy_r, qx_r, qy_r;
  fvn_pkg::shifted_t sx_r, sy_r;
  fvn_pkg::contrib_t contrib [OCTAVES];
  logic signed [31:0] total_r, total_nxt, out_total_r;
  logic [32:0] mag;
  logic [2:0] out_level_r, level_nxt;

  // quotient estimate by reciprocal, at most one short of the true value
  function automatic logic [9:0] quot_est(input logic [9:0] v);
    return 10'((32'(v) * 32'(RECIP)) >> 20);
  endfunction

  function automatic logic [9:0] reduce(input logic [9:0] v, input logic [9:0] q);
    logic [27:0] r;
    r = 28'(v) - 28'(q) * 28'(MAP_SIZE);
    if (r >= 28'(MAP_SIZE)) r = r - 28'(MAP_SIZE);
    return r[9:0];
  endfunction

  assign en        = !vld_r[DEPTH-1] || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= fvn_pkg::OFFSET_RST;
      freq_r    <= fvn_pkg::FREQ_RST;
      amp_cfg_r <= fvn_pkg::AMP_RST;
      pers_r    <= fvn_pkg::PERSIST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fvn_pkg::REG_OFFSET:  offset_r  <= cfg_data;
        fvn_pkg::REG_FREQ:    freq_r    <= cfg_data[15:0];
        fvn_pkg::REG_AMP:     amp_cfg_r <= cfg_data[23:0];
        fvn_pkg::REG_PERSIST: pers_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // amplitude of each octave, recomputed every cycle
  always_ff @(posedge clk) begin
    amp_r[0] <= amp_cfg_r;
    for (int k = 1; k < OCTAVES; k++) begin
      amp_r[k] <= 24'((40'(amp_r[k-1]) * 40'(pers_r)) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    total_nxt = 32'sd1 <<< 24;
    for (int k = 0; k < OCTAVES; k++) begin
      total_nxt = total_nxt + 32'(contrib[k]);
    end
    mag = total_r[31] ? 33'(-(33'(total_r))) : 33'(total_r);
    level_nxt = (mag[32:23] > 10'd7) ? 3'd7 : mag[25:23];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= in_coord_x;
      cy_r <= in_coord_y;
      qx_r <= quot_est(in_coord_x);
      qy_r <= quot_est(in_coord_y);
      sx_r <= 33'({reduce(cx_r, qx_r), 8'd0}) + 33'(offset_r);
      sy_r <= 33'({reduce(cy_r, qy_r), 8'd0}) + 33'(offset_r);
      total_r     <= total_nxt;
      out_total_r <= total_r;
      out_level_r <= level_nxt;
    end
  end

  for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
    fvn_octave #(.K(k)) u_oct (
      .clk       (clk),
      .en        (en),
      .base_freq (freq_r),
      .sx        (sx_r),
      .sy        (sy_r),
      .amp       (amp_r[k]),
      .contrib   (contrib[k])
    );
  end

  assign out_valid       = vld_r[DEPTH-1];
  assign out_total_value = out_total_r;
  assign out_level       = out_level_r;

`ifndef SYNTH
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result waiting");

  a_level_small: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_total_value[31] && out_total_value[30:26] == 5'd0)
      |-> out_level == out_total_value[25:23])
    else $error("level does not match total");
`endif

endmodule
`default_nettype wire

@@ design/fvn_hash.sv @@
// Four-stage pipelined 32-bit lattice hash, result as signed Q2.30.
`timescale 1ns / 1ps
`default_nettype none
module fvn_hash (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [31:0]   x,
  input  wire logic [31:0]   y,
  output fvn_pkg::hash_t     h
);

  logic [31:0] n0;
  logic [31:0] n_r, n2_r, n3_r, sq_r, t_r;
  logic [31:0] n_nxt, sq_nxt, t_nxt, m_nxt;
  fvn_pkg::hash_t h_r, h_nxt;

  always_comb begin
    n0     = x + y * fvn_pkg::HASH_Y_MUL;
    n_nxt  = (n0 << fvn_pkg::HASH_SHIFT) ^ n0;
    sq_nxt = n_r * n_r;
    t_nxt  = sq_r * fvn_pkg::HASH_SQ_MUL + fvn_pkg::HASH_ADD1;
    m_nxt  = (n3_r * t_r + fvn_pkg::HASH_ADD2) & fvn_pkg::HASH_MASK;
    h_nxt  = $signed(fvn_pkg::HASH_ONE - m_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= n_nxt;
      sq_r <= sq_nxt;
      n2_r <= n_r;
      t_r  <= t_nxt;
      n3_r <= n2_r;
      h_r  <= h_nxt;
    end
  end

  assign h = h_r;

endmodule
`default_nettype wire

@@ design/fvn_octave.sv @@
// One noise octave: scale, hash a 4x4 lattice patch, smooth, blend, weight.
`timescale 1ns / 1ps
`default_nettype none
module fvn_octave #(
  parameter int K = 0
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [15:0]       base_freq,
  input  wire fvn_pkg::shifted_t sx,
  input  wire fvn_pkg::shifted_t sy,
  input  wire logic [23:0]       amp,
  output fvn_pkg::contrib_t      contrib
);

  logic [63:0] freq;
  logic [63:0] px_r, py_r, px_nxt, py_nxt;
  logic [31:0] ix, iy;
  logic [15:0] fxd_r [6];
  logic [15:0] fyd_r [6];
  fvn_pkg::hash_t  h [4][4];
  fvn_pkg::smooth_t sm_r [2][2];
  fvn_pkg::smooth_t sm_nxt [2][2];
  fvn_pkg::smooth_t top_r, bot_r, v_r, top_nxt, bot_nxt, v_nxt;
  logic signed [36:0] dt, db, dv;
  logic signed [53:0] pt, pb, pv;
  logic signed [60:0] pa;
  fvn_pkg::contrib_t contrib_r;

  assign freq   = 64'(base_freq) << K;
  assign px_nxt = 64'(sx) * freq;
  assign py_nxt = 64'(sy) * freq;
  assign ix     = px_r[55:24];
  assign iy     = py_r[55:24];

  // 4x4 patch around the cell, index 0 is one below the lattice point
  for (genvar i = 0; i < 4; i++) begin : g_x
    for (genvar j = 0; j < 4; j++) begin : g_y
      fvn_hash u_hash (
        .clk (clk),
        .en  (en),
        .x   (ix + 32'(i) - 32'd1),
        .y   (iy + 32'(j) - 32'd1),
        .h   (h[i][j])
      );
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        sm_nxt[a][b] = 36'(h[a][b]) + 36'(h[a+2][b]) + 36'(h[a][b+2]) + 36'(h[a+2][b+2])
                     + ((36'(h[a][b+1]) + 36'(h[a+2][b+1]) + 36'(h[a+1][b])
                       + 36'(h[a+1][b+2])) <<< 1)
                     + (36'(h[a+1][b+1]) <<< 2);
      end
    end
    dt = 37'(sm_r[1][0]) - 37'(sm_r[0][0]);
    db = 37'(sm_r[1][1]) - 37'(sm_r[0][1]);
    pt = 54'(dt) * 54'($signed({1'b0, fxd_r[4]}));
    pb = 54'(db) * 54'($signed({1'b0, fxd_r[4]}));
    top_nxt = 36'(54'(sm_r[0][0]) + (pt >>> 16));
    bot_nxt = 36'(54'(sm_r[0][1]) + (pb >>> 16));
    dv = 37'(bot_r) - 37'(top_r);
    pv = 54'(dv) * 54'($signed({1'b0, fyd_r[5]}));
    v_nxt = 36'(54'(top_r) + (pv >>> 16));
    pa = 61'(v_r) * 61'($signed({1'b0, amp}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      fxd_r[0] <= px_r[23:8];
      fyd_r[0] <= py_r[23:8];
      for (int d = 1; d < 6; d++) begin
        fxd_r[d] <= fxd_r[d-1];
        fyd_r[d] <= fyd_r[d-1];
      end
      sm_r      <= sm_nxt;
      top_r     <= top_nxt;
      bot_r     <= bot_nxt;
      v_r       <= v_nxt;
      contrib_r <= 26'(pa >>> 34);
    end
  end

  assign contrib = contrib_r;

endmodule
`default_nettype wire

@@ dv/fractal_value_noise_2d_tb.sv @@
// Self-checking testbench for the fractal 2D value-noise generator.
`timescale 1ns / 1ps
`default_nettype none
module fractal_value_noise_2d_tb;

  localparam int NOISE_OCTAVES = 2;
  localparam int MAP_SIDE      = 1024;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic signed [31:0] total;
    logic [2:0]         level;
  } height_t;

  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
    logic       has_gold;
    height_t    gold;
  } coord_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [9:0] in_coord_x = '0;
  logic [9:0] in_coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_total_value;
  logic [2:0] out_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  fvn_pkg::cfg_reg_t cfg_index = fvn_pkg::REG_OFFSET;
  logic [31:0] cfg_data = '0;

  fractal_value_noise_2d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_total_value(out_total_value), .out_level(out_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the registers
  logic [31:0] sh_offset  = fvn_pkg::OFFSET_RST;
  logic [15:0] sh_freq    = fvn_pkg::FREQ_RST;
  logic [23:0] sh_amp     = fvn_pkg::AMP_RST;
  logic [15:0] sh_persist = fvn_pkg::PERSIST_RST;

  height_t pending_heights[$];
  int errors = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_recv_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout at %0t", $time);
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint lattice_value(logic [31:0] x, logic [31:0] y);
    logic [31:0] n;
    logic [31:0] m;
    n = x + y * 32'd57;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return longint'(32'h40000000) - longint'(m);
  endfunction

  function automatic longint kernel_value(logic [31:0] x, logic [31:0] y);
    longint c;
    longint s;
    c = lattice_value(x - 1, y - 1) + lattice_value(x + 1, y - 1)
      + lattice_value(x - 1, y + 1) + lattice_value(x + 1, y + 1);
    s = lattice_value(x - 1, y) + lattice_value(x + 1, y)
      + lattice_value(x, y - 1) + lattice_value(x, y + 1);
    return c + 2 * s + 4 * lattice_value(x, y);
  endfunction

  function automatic longint lerp_q16(longint a, longint b, logic [15:0] f);
    return a + floor_shr((b - a) * longint'({1'b0, f}), 16);
  endfunction

  function automatic height_t noise_height(logic [9:0] cx, logic [9:0] cy);
    logic [63:0] sx;
    logic [63:0] sy;
    logic [63:0] freq;
    logic [63:0] amp;
    logic [63:0] px;
    logic [63:0] py;
    longint total;
    longint top;
    longint bot;
    longint v;
    longint mag;
    longint lvl;
    height_t h;
    sx = 64'(cx % MAP_SIDE) * 256 + 64'(sh_offset);
    sy = 64'(cy % MAP_SIDE) * 256 + 64'(sh_offset);
    freq = 64'(sh_freq);
    amp = 64'(sh_amp);
    total = 64'sd1 << 24;
    for (int k = 0; k < NOISE_OCTAVES; k++) begin
      px = sx * freq;
      py = sy * freq;
      top = lerp_q16(kernel_value(px[55:24], py[55:24]),
                     kernel_value(px[55:24] + 1, py[55:24]), px[23:8]);
      bot = lerp_q16(kernel_value(px[55:24], py[55:24] + 1),
                     kernel_value(px[55:24] + 1, py[55:24] + 1), px[23:8]);
      v = lerp_q16(top, bot, py[23:8]);
      total += floor_shr(v * longint'(amp), 34);
      amp = (amp * 64'(sh_persist)) >> 16;
      freq = freq << 1;
    end
    mag = total < 0 ? -total : total;
    lvl = (mag * 2) >>> 24;
    if (lvl > 7) lvl = 7;
    h.total = total[31:0];
    h.level = lvl[2:0];
    return h;
  endfunction

  // result side: stall process and checker
  always @(negedge clk) begin
    if (hold_recv_cycles > 0) begin
      out_stall <= 1'b1;
      hold_recv_cycles <= hold_recv_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    height_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_heights.size() == 0) begin
        errors++;
        $display("%0t: unexpected result total=%0d level=%0d", $time,
                 out_total_value, out_level);
      end else begin
        want = pending_heights.pop_front();
        checked++;
        if (out_total_value !== want.total) begin
          errors++;
          $display("%0t: total_value expected %0d actual %0d", $time,
                   want.total, out_total_value);
        end
        if (out_level !== want.level) begin
          errors++;
          $display("%0t: level expected %0d actual %0d", $time,
                   want.level, out_level);
        end
      end
    end
  end

  // valid stays high on return; the next call or drain_pipe drops it
  task automatic send_coord(logic [9:0] x, logic [9:0] y, bit has_gold, height_t gold);
    height_t h;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    h = noise_height(x, y);
    if (has_gold && h !== gold) begin
      errors++;
      $display("%0t: table row (%0d,%0d) expected %0d/%0d predictor %0d/%0d",
               $time, x, y, gold.total, gold.level, h.total, h.level);
    end
    pending_heights.push_back(has_gold ? gold : h);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_heights.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(fvn_pkg::cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      fvn_pkg::REG_OFFSET:  sh_offset  = data;
      fvn_pkg::REG_FREQ:    sh_freq    = data[15:0];
      fvn_pkg::REG_AMP:     sh_amp     = data[23:0];
      fvn_pkg::REG_PERSIST: sh_persist = data[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic random_burst(int count);
    height_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0)
        send_coord($urandom_range(1) ? 10'h3ff : 10'h000, 10'($urandom), 1'b0, none);
      else
        send_coord(10'($urandom), 10'($urandom), 1'b0, none);
    end
  endtask

  coord_row_t coord_table[] = '{
    // map corners, edges and a few interior points
    '{10'd0,   10'd0,   1'b0, '0},
    '{10'd1023,10'd1023,1'b0, '0},
    '{10'd0,   10'd1023,1'b0, '0},
    '{10'd1023,10'd0,   1'b0, '0},
    '{10'd512, 10'd511, 1'b0, '0},
    '{10'h155, 10'h2aa, 1'b0, '0},
    '{10'h2aa, 10'h155, 1'b0, '0},
    '{10'd1,   10'd2,   1'b0, '0},
    '{10'd100, 10'd37,  1'b0, '0},
    '{10'd999, 10'd3,   1'b0, '0}
  };

  initial begin
    height_t none;
    height_t unity;
    none = '0;
    unity.total = 32'sd16777216;
    unity.level = 3'd2;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: defaults, then zero amplitude gives exactly one
    foreach (coord_table[i])
      send_coord(coord_table[i].x, coord_table[i].y, coord_table[i].has_gold,
                 coord_table[i].gold);
    drain_pipe();
    write_reg(fvn_pkg::REG_AMP, 32'd0);
    foreach (coord_table[i])
      send_coord(coord_table[i].x, coord_table[i].y, 1'b1, unity);
    drain_pipe();
    // extremes: full amplitude, top frequency, all-ones offset, full persistence
    write_reg(fvn_pkg::REG_AMP, 32'hffffff);
    write_reg(fvn_pkg::REG_FREQ, 32'hffff);
    write_reg(fvn_pkg::REG_OFFSET, 32'hffffffff);
    write_reg(fvn_pkg::REG_PERSIST, 32'hffff);
    foreach (coord_table[i])
      send_coord(coord_table[i].x, coord_table[i].y, 1'b0, none);
    drain_pipe();

    // random phases with varied register settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 6;  recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(fvn_pkg::REG_OFFSET, (ph == 5) ? 32'h0 : $urandom);
      write_reg(fvn_pkg::REG_FREQ, (ph == 4) ? 32'h0 : $urandom_range(65535));
      write_reg(fvn_pkg::REG_AMP,
                $urandom_range(1) ? 32'hffffff : $urandom_range(16777215));
      write_reg(fvn_pkg::REG_PERSIST, (ph == 3) ? 32'h0 : $urandom_range(65535));
      if (ph == 2) hold_recv_cycles = 60;  // long hold-off fills the pipeline
      random_burst(265);
      drain_pipe();  // sender pauses until every result is back
    end

    $display("checked %0d heights over directed extremes and six random register sets",
             checked);
    if (errors == 0 && pending_heights.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
